[hw/rtl/dnamse_pkg.sv]
// Shared types and constants for the DNA marker stream encoder.
package dnamse_pkg;

   // Input operation codes (carried on req_tuser)
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Result kinds (carried on rsp_tuser[1:0])
   localparam logic [1:0] KIND_BASE   = 2'd0;
   localparam logic [1:0] KIND_MARKER = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   // Base codes
   localparam logic [63:0] CODE_A = 64'd1;
   localparam logic [63:0] CODE_C = 64'd2;
   localparam logic [63:0] CODE_G = 64'd3;
   localparam logic [63:0] CODE_T = 64'd4;

   // Character constants
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_C  = 8'h43;
   localparam logic [7:0] CHAR_UP_G  = 8'h47;
   localparam logic [7:0] CHAR_UP_T  = 8'h54;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_C  = 8'h63;
   localparam logic [7:0] CHAR_LO_G  = 8'h67;
   localparam logic [7:0] CHAR_LO_T  = 8'h74;

   // One queued result
   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] value;
      logic        overflow;
      logic        last;
   } result_type;

endpackage

[hw/rtl/dna_marker_stream_encoder_unit.sv]
// Top level of the DNA marker stream encoder.
//
// Usage:
//   req channel: one text byte per transfer. req_tdata holds the character,
//   req_tuser the operation (0 = data byte, 1 = end of stream).
//   rsp channel: one result per transfer. rsp_tdata holds the value (base
//   code, marker number or symbol count), rsp_tuser the kind and the
//   saturation flag, rsp_tlast marks the last result of an input item.
//   Bases map to codes 1..4, digit runs build a marker that is sent just
//   before the next base or at end of stream; other bytes are dropped.
//   Results are registered in a queue. Throughput: one byte per cycle while
//   two queue slots are free. Each byte yields zero, one or two results;
//   the four-entry result queue needs two free slots to take a byte, so
//   a sustained stream of two-result items runs at the rsp rate.
//   Reset clears the marker state, symbol count and the result queue.
//   When the receiver stalls, results collect in the queue and req_tready
//   drops once fewer than two slots are free; nothing is lost.
module dna_marker_stream_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] value
   output logic [2:0]  rsp_tuser,   // [1:0] kind, [2] overflow
   output logic        rsp_tlast
);

   // Marker and count state
   logic [63:0] accum_ff, accum_in;
   logic        pending_ff, pending_in;
   logic        saturated_ff, saturated_in;
   logic [63:0] count_ff, count_in;

   // Result queue
   dnamse_pkg::result_type queue_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] fill_ff, fill_in;

   logic        req_xfer, rsp_xfer;
   logic        is_end, is_base, is_digit;
   logic [63:0] base_code;
   logic [3:0]  digit;
   logic [67:0] accum_next_wide;
   logic        accum_ovf;
   logic        put_marker, put_main;
   dnamse_pkg::result_type marker_res, main_res;
   logic [1:0]  put_count;

   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign req_tready = (fill_ff <= 3'd2);
   assign rsp_tvalid = (fill_ff != 3'd0);

   // Decode the incoming byte
   always_comb begin
      is_end    = (req_tuser == dnamse_pkg::OP_END);
      base_code = 64'd0;
      case (req_tdata)
         dnamse_pkg::CHAR_UP_A, dnamse_pkg::CHAR_LO_A: base_code = dnamse_pkg::CODE_A;
         dnamse_pkg::CHAR_UP_C, dnamse_pkg::CHAR_LO_C: base_code = dnamse_pkg::CODE_C;
         dnamse_pkg::CHAR_UP_G, dnamse_pkg::CHAR_LO_G: base_code = dnamse_pkg::CODE_G;
         dnamse_pkg::CHAR_UP_T, dnamse_pkg::CHAR_LO_T: base_code = dnamse_pkg::CODE_T;
         default:                                      base_code = 64'd0;
      endcase
      is_base  = !is_end && (base_code != 64'd0);
      is_digit = !is_end
                 && (req_tdata inside {[dnamse_pkg::CHAR_ZERO:dnamse_pkg::CHAR_NINE]});
   end

   // Multiply by ten as shift-add, flag carry out of 64 bits
   assign digit           = 4'(req_tdata - dnamse_pkg::CHAR_ZERO);
   assign accum_next_wide = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1)
                            + {64'd0, digit};
   assign accum_ovf       = saturated_ff || (accum_next_wide[67:64] != 4'd0);

   // Build the results of this transfer
   always_comb begin
      put_marker          = pending_ff && (is_end || is_base);
      put_main            = is_end || is_base;
      marker_res.kind     = dnamse_pkg::KIND_MARKER;
      marker_res.value    = accum_ff;
      marker_res.overflow = saturated_ff;
      marker_res.last     = 1'b0;
      main_res.kind       = is_end ? dnamse_pkg::KIND_END : dnamse_pkg::KIND_BASE;
      main_res.value      = is_end ? (count_ff + {63'd0, pending_ff}) : base_code;
      main_res.overflow   = 1'b0;
      main_res.last       = 1'b1;
      put_count           = {1'b0, put_marker} + {1'b0, put_main};
   end

   // Next marker and count state
   always_comb begin
      accum_in     = accum_ff;
      pending_in   = pending_ff;
      saturated_in = saturated_ff;
      count_in     = count_ff;
      if (req_xfer) begin
         if (is_end) begin
            accum_in     = 64'd0;
            pending_in   = 1'b0;
            saturated_in = 1'b0;
            count_in     = 64'd0;
         end else if (is_base) begin
            accum_in     = 64'd0;
            pending_in   = 1'b0;
            saturated_in = 1'b0;
            count_in     = count_ff + {63'd0, pending_ff} + 64'd1;
         end else if (is_digit) begin
            accum_in     = accum_ovf ? {64{1'b1}} : accum_next_wide[63:0];
            saturated_in = accum_ovf;
            pending_in   = 1'b1;
         end
      end
   end

   // Advance queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (req_xfer) begin
         wr_ptr_in = wr_ptr_ff + put_count;
      end
      if (rsp_xfer) begin
         rd_ptr_in = rd_ptr_ff + 2'd1;
      end
      fill_in = fill_ff + (req_xfer ? {1'b0, put_count} : 3'd0) - {2'd0, rsp_xfer};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= 64'd0;
         pending_ff   <= 1'b0;
         saturated_ff <= 1'b0;
         count_ff     <= 64'd0;
         wr_ptr_ff    <= 2'd0;
         rd_ptr_ff    <= 2'd0;
         fill_ff      <= 3'd0;
      end else begin
         accum_ff     <= accum_in;
         pending_ff   <= pending_in;
         saturated_ff <= saturated_in;
         count_ff     <= count_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
      end
   end

   // Write up to two results into the queue
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         if (put_marker) begin
            queue_ff[wr_ptr_ff]        <= marker_res;
            queue_ff[wr_ptr_ff + 2'd1] <= main_res;
         end else if (put_main) begin
            queue_ff[wr_ptr_ff]        <= main_res;
         end
      end
   end

   // Drive the result channel from the queue head
   assign rsp_tdata = queue_ff[rd_ptr_ff].value;
   assign rsp_tuser = {queue_ff[rd_ptr_ff].overflow, queue_ff[rd_ptr_ff].kind};
   assign rsp_tlast = queue_ff[rd_ptr_ff].last;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 3'd4)
      else $error("result queue overfilled");

   a_ptr_fill: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == fill_ff[1:0])
      else $error("queue pointers disagree with fill level");

   a_sat_ones: assert property (@(posedge clock) disable iff (reset)
      saturated_ff |-> (pending_ff && (accum_ff == {64{1'b1}})))
      else $error("saturated marker not at all ones");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && is_end) |=> (!pending_ff && (count_ff == 64'd0)
                                && (accum_ff == 64'd0)))
      else $error("end of stream did not clear state");

   a_idle_accum: assert property (@(posedge clock) disable iff (reset)
      !pending_ff |-> (accum_ff == 64'd0))
      else $error("accumulator nonzero without pending marker");

endmodule

[bench/marker_stream_checker.sv]
`timescale 1ns / 100ps
// Result checker for the marker stream encoder: predicts results from req transfers.
module marker_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_byte
   input  logic        req_tuser,    // [0] operation
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,    // [63:0] value
   input  logic [2:0]  rsp_tuser,    // [1:0] kind, [2] overflow
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          results_due
);

   // Results owed by the encoder, oldest first
   dnamse_pkg::result_type expected_results[$];

   // Encoder state as the checker tracks it
   logic [63:0] marker_value;
   logic        marker_open;
   logic        marker_clipped;
   logic [63:0] symbols_sent;

   task automatic report_mismatch(input string what);
      $display("%0t ns: rsp mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic owe_result(input logic [1:0] kind, input logic [63:0] value,
                             input logic ovf, input logic last);
      dnamse_pkg::result_type r;
      r.kind     = kind;
      r.value    = value;
      r.overflow = ovf;
      r.last     = last;
      expected_results.insert(expected_results.size(), r);
   endtask

   task automatic clear_stream();
      marker_value   = '0;
      marker_open    = 1'b0;
      marker_clipped = 1'b0;
      symbols_sent   = '0;
   endtask

   // Emit the marker collected so far, if any digit was seen
   task automatic flush_marker();
      if (marker_open) begin
         owe_result(dnamse_pkg::KIND_MARKER, marker_value, marker_clipped, 1'b0);
         symbols_sent   = symbols_sent + 64'd1;
         marker_value   = '0;
         marker_open    = 1'b0;
         marker_clipped = 1'b0;
      end
   endtask

   function automatic logic [63:0] base_code_of(input logic [7:0] ch);
      case (ch)
         dnamse_pkg::CHAR_UP_A, dnamse_pkg::CHAR_LO_A: return dnamse_pkg::CODE_A;
         dnamse_pkg::CHAR_UP_C, dnamse_pkg::CHAR_LO_C: return dnamse_pkg::CODE_C;
         dnamse_pkg::CHAR_UP_G, dnamse_pkg::CHAR_LO_G: return dnamse_pkg::CODE_G;
         dnamse_pkg::CHAR_UP_T, dnamse_pkg::CHAR_LO_T: return dnamse_pkg::CODE_T;
         default:                                      return 64'd0;
      endcase
   endfunction

   // Work out what one accepted byte or end item owes on rsp
   task automatic predict_encoder(input logic op, input logic [7:0] ch);
      logic [63:0] code;
      logic [67:0] grown;
      logic [3:0]  digit;
      if (op == dnamse_pkg::OP_END) begin
         flush_marker();
         owe_result(dnamse_pkg::KIND_END, symbols_sent, 1'b0, 1'b1);
         clear_stream();
         return;
      end
      code = base_code_of(ch);
      if (code != 64'd0) begin
         flush_marker();
         owe_result(dnamse_pkg::KIND_BASE, code, 1'b0, 1'b1);
         symbols_sent = symbols_sent + 64'd1;
      end else if (ch inside {[dnamse_pkg::CHAR_ZERO:dnamse_pkg::CHAR_NINE]}) begin
         // accumulate the digit; clip at all ones once past 64 bits
         digit = 4'(ch - dnamse_pkg::CHAR_ZERO);
         grown = {4'd0, marker_value} * 68'd10 + {64'd0, digit};
         if (marker_clipped || grown > {4'd0, {64{1'b1}}}) begin
            marker_value   = {64{1'b1}};
            marker_clipped = 1'b1;
         end else begin
            marker_value = grown[63:0];
         end
         marker_open = 1'b1;
      end
   endtask

   // Compare each rsp transfer, then account for the req transfer of this edge
   always @(posedge clock) begin
      dnamse_pkg::result_type want;
      if (reset) begin
         clear_stream();
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d value 0x%0h",
                                         rsp_tuser[1:0], rsp_tdata));
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser[1:0] != want.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d",
                                            rsp_tuser[1:0], want.kind));
               if (rsp_tdata != want.value)
                  report_mismatch($sformatf("value 0x%0h, expected 0x%0h",
                                            rsp_tdata, want.value));
               if (rsp_tuser[2] != want.overflow)
                  report_mismatch($sformatf("overflow %0b, expected %0b",
                                            rsp_tuser[2], want.overflow));
               if (rsp_tlast != want.last)
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp_tlast, want.last));
            end
         end
         if (req_tvalid && req_tready)
            predict_encoder(req_tuser, req_tdata);
      end
      results_due <= expected_results.size();
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Testbench top: stimulus, receiver stalls and verdict for the marker stream encoder.
module tb;

   localparam int RANDOM_ITEMS = 1800;
   localparam int HOLD_CYCLES  = 80;
   localparam int RUN_LIMIT    = 400000;
   localparam string MAX_MARKER = "18446744073709551615";
   localparam logic [7:0] LETTERS [8] = '{dnamse_pkg::CHAR_UP_A, dnamse_pkg::CHAR_UP_C,
                                          dnamse_pkg::CHAR_UP_G, dnamse_pkg::CHAR_UP_T,
                                          dnamse_pkg::CHAR_LO_A, dnamse_pkg::CHAR_LO_C,
                                          dnamse_pkg::CHAR_LO_G, dnamse_pkg::CHAR_LO_T};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] char_byte
   logic        req_tuser  = dnamse_pkg::OP_DATA; // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [63:0] value
   logic [2:0]  rsp_tuser;           // [1:0] kind, [2] overflow
   logic        rsp_tlast;

   int   mismatch_count;
   int   results_due;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   traffic_phase = 0;
   int   cycle_count   = 0;
   logic rsp_hold      = 1'b0;

   always #5 clock = ~clock;

   dna_marker_stream_encoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   marker_stream_checker result_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   // Receiver: stall at random, or hold off entirely while rsp_hold is set
   always @(posedge clock)
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);

   // Long receiver hold-off early in the no-idle phase so the queue fills
   initial begin
      wait (traffic_phase == 2);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("dna_marker_stream_encoder_unit verification failed");
         $finish;
      end
   end

   task automatic set_phase(input int p);
      traffic_phase <= p;
      case (p)
         0:       begin send_idle_pct = 12; recv_idle_pct <= 87; end
         1:       begin send_idle_pct = 87; recv_idle_pct <= 12; end
         default: begin send_idle_pct = 0;  recv_idle_pct <= 0;  end
      endcase
   endtask

   // Offer one req transfer and hold it until taken
   task automatic send_item(input logic op, input logic [7:0] ch);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(dnamse_pkg::OP_DATA, s[i]);
   endtask

   // One random piece of text: a base, a digit run, stray bytes or an end
   task automatic send_random_chunk(inout int items_sent);
      int pick;
      int len;
      pick = $urandom_range(99);
      if (pick < 40) begin
         send_item(dnamse_pkg::OP_DATA, LETTERS[$urandom_range(7)]);
         items_sent++;
      end else if (pick < 65) begin
         // short marker, sometimes broken up by stray bytes
         len = $urandom_range(1, 4);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) begin
               send_item(dnamse_pkg::OP_DATA, 8'($urandom_range(255)));
               items_sent++;
            end
            send_item(dnamse_pkg::OP_DATA, 8'(dnamse_pkg::CHAR_ZERO + $urandom_range(9)));
            items_sent++;
         end
      end else if (pick < 73) begin
         // markers near and past the 64-bit limit
         if ($urandom_range(2) == 0) begin
            send_text(MAX_MARKER);
            items_sent += MAX_MARKER.len();
            if ($urandom_range(1) == 1) begin
               send_item(dnamse_pkg::OP_DATA,
                         8'(dnamse_pkg::CHAR_ZERO + $urandom_range(9)));
               items_sent++;
            end
         end else begin
            len = $urandom_range(18, 23);
            for (int i = 0; i < len; i++)
               send_item(dnamse_pkg::OP_DATA,
                         8'(dnamse_pkg::CHAR_ZERO + $urandom_range(9)));
            items_sent += len;
         end
      end else if (pick < 96) begin
         send_item(dnamse_pkg::OP_DATA, 8'($urandom_range(255)));
         items_sent++;
      end else begin
         send_item(dnamse_pkg::OP_END, 8'($urandom_range(255)));
         items_sent++;
      end
   endtask

   initial begin
      int items_sent;
      items_sent = 0;
      set_phase(0);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // all letters in both cases
      send_text("AcGt");
      send_text("aCgT");
      // zero marker then a base
      send_text("0A");
      // stray bytes inside a digit run do not end it
      send_text("9");
      send_item(dnamse_pkg::OP_DATA, 8'h00);
      send_text("1");
      send_item(dnamse_pkg::OP_DATA, 8'hFF);
      send_text("T");
      // pending marker flushed at end of stream; char_byte ignored on end
      send_text("75");
      send_item(dnamse_pkg::OP_END, 8'hFF);
      // end on an empty stream, then a fresh stream with one base
      send_item(dnamse_pkg::OP_END, 8'h00);
      send_text("g");
      send_item(dnamse_pkg::OP_END, 8'h5A);

      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= 2 * RANDOM_ITEMS / 3)
            set_phase(2);
         else if (items_sent >= RANDOM_ITEMS / 3)
            set_phase(1);
         send_random_chunk(items_sent);
      end
      req_tvalid <= 1'b0;

      // drain outstanding results
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("dna_marker_stream_encoder_unit verification clean");
      else
         $display("dna_marker_stream_encoder_unit verification failed");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/dnamse_pkg.sv
hw/rtl/dna_marker_stream_encoder_unit.sv
bench/marker_stream_checker.sv
bench/tb.sv
